// ===== sv/ltr_pkg.sv =====
`default_nettype none
package ltr_pkg;

    // framing bytes
    localparam logic [7:0] STX_BYTE  = 8'h02;
    localparam logic [7:0] SCAN_TYPE = 8'hB0;

    // header byte positions and sizes
    localparam int REPLAY_DEPTH    = 5;
    localparam int REPLAY_IDX_W    = $clog2(REPLAY_DEPTH);
    localparam int FRAME_OVERHEAD  = 6;
    localparam int MAX_MEASUREMENTS = 1024;

    // field widths
    localparam int POS_W        = 17;
    localparam int COUNT_W      = 16;
    localparam int MEAS_INDEX_W = 10;
    localparam int RANGE_W      = 13;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd3;

    // result kinds
    localparam logic KIND_MEAS   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [STATUS_W-1:0] FS_ACCEPTED     = 2'd0;
    localparam logic [STATUS_W-1:0] FS_CRC_ERROR    = 2'd1;
    localparam logic [STATUS_W-1:0] FS_UNKNOWN_TYPE = 2'd2;
    localparam logic [STATUS_W-1:0] FS_WRONG_COUNT  = 2'd3;

    typedef struct packed {
        logic [15:0]  crc_polynomial;
        logic [16:0]  max_frame_bytes;
        logic [10:0]  expected_count;
        logic [RANGE_W-1:0] max_range;
    } t_cfg;

    typedef struct packed {
        logic                    item_kind;
        logic [MEAS_INDEX_W-1:0] meas_index;
        logic [RANGE_W-1:0]      range_value;
        logic                    dazzle_flag;
        logic                    warn_field_flag;
        logic                    stop_field_flag;
        logic [STATUS_W-1:0]     frame_status;
        logic                    request_next;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic                    feed;
        logic                    in_frame;
        logic                    replay;
        logic [REPLAY_IDX_W-1:0] rep_idx;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_byte;
        logic oversize;
        logic frame_end;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== sv/ltr_byte_if.sv =====
`default_nettype none
interface ltr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/ltr_result_if.sv =====
`default_nettype none
interface ltr_result_if;
    import ltr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    item_kind;
    logic [MEAS_INDEX_W-1:0] meas_index;
    logic [RANGE_W-1:0]      range_value;
    logic                    dazzle_flag;
    logic                    warn_field_flag;
    logic                    stop_field_flag;
    logic [STATUS_W-1:0]     frame_status;
    logic                    request_next;

    modport source (output valid, output item_kind, output meas_index, output range_value,
                    output dazzle_flag, output warn_field_flag, output stop_field_flag,
                    output frame_status, output request_next, input ready);
    modport sink   (input valid, input item_kind, input meas_index, input range_value,
                    input dazzle_flag, input warn_field_flag, input stop_field_flag,
                    input frame_status, input request_next, output ready);
endinterface
`default_nettype wire

// ===== sv/ltr_cfg_if.sv =====
`default_nettype none
interface ltr_cfg_if;
    import ltr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/laser_telegram_receiver.sv =====
`default_nettype none
// Telegram receiver for a serial range scanner.
// i_byte carries one link byte per word. The block hunts for STX, reads the
// address and little-endian length, checks the CRC16 and, for a scan frame
// with the expected count, sends one measurement word on o_res per value as
// its high byte arrives, plus one status word at the last CRC byte.
// Keep the measurements only if the status word reports an accepted scan.
// i_cfg writes the four setup registers (index 0..3); write only while idle.
// Throughput: one byte per cycle. A header whose length exceeds the limit
// stalls the link: the five held header bytes are fed again through the
// same byte datapath, one per cycle, with i_byte.ready low.
// A result word is registered in a two-word queue that o_res drains;
// while the queue holds two words, i_byte.ready stays low, so a stalled
// consumer backs up the link.
// Reset (i_rst_n low at a clock edge) returns to hunting, empties the queue
// and restores the register defaults.
module laser_telegram_receiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ltr_byte_if.sink            i_byte,
    ltr_cfg_if.sink             i_cfg,
    ltr_result_if.source        o_res
);
    import ltr_pkg::*;

    t_cfg       r_cfg;
    t_ctrl_cmd  cmd;
    t_dp_status dp_status;
    t_result    dp_result, q_data;
    logic       dp_emit;
    logic       q_full, q_valid;
    logic       accept;
    logic       pop;

    assign i_byte.ready = !cmd.replay && !q_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;

    // setup registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_polynomial  <= 16'h8005;
            r_cfg.max_frame_bytes <= 17'd812;
            r_cfg.expected_count  <= 11'd361;
            r_cfg.max_range       <= 13'd8191;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CRC_POLY:  r_cfg.crc_polynomial  <= i_cfg.data[15:0];
                CFG_MAX_FRAME: r_cfg.max_frame_bytes <= i_cfg.data[16:0];
                CFG_EXP_COUNT: r_cfg.expected_count  <= i_cfg.data[10:0];
                CFG_MAX_RANGE: r_cfg.max_range       <= i_cfg.data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    ltr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    ltr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_data_byte (i_byte.data_byte),
        .o_status    (dp_status),
        .o_emit      (dp_emit),
        .o_result    (dp_result)
    );

    assign pop = q_valid && o_res.ready;

    ltr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dp_emit),
        .i_data  (dp_result),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign o_res.valid           = q_valid;
    assign o_res.item_kind       = q_data.item_kind;
    assign o_res.meas_index      = q_data.meas_index;
    assign o_res.range_value     = q_data.range_value;
    assign o_res.dazzle_flag     = q_data.dazzle_flag;
    assign o_res.warn_field_flag = q_data.warn_field_flag;
    assign o_res.stop_field_flag = q_data.stop_field_flag;
    assign o_res.frame_status    = q_data.frame_status;
    assign o_res.request_next    = q_data.request_next;

    // a result is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_emit |-> !q_full)
        else $error("result pushed into full queue");

    // an oversized header always stalls the link for the replay
    a_replay_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && dp_status.oversize) |=> !i_byte.ready)
        else $error("link not stalled after oversized header");

    // replayed header bytes never end a frame or trip the size check
    a_replay_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.replay |-> (!dp_status.oversize && !dp_status.frame_end && !dp_emit))
        else $error("replay produced frame event");

endmodule
`default_nettype wire

// ===== sv/ltr_ctrl.sv =====
`default_nettype none
module ltr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  ltr_pkg::t_dp_status   i_status,
    output ltr_pkg::t_ctrl_cmd    o_cmd
);
    import ltr_pkg::*;

    localparam logic [1:0] S_HUNT     = 2'd0;
    localparam logic [1:0] S_FRAME    = 2'd1;
    localparam logic [1:0] S_RP_HUNT  = 2'd2;
    localparam logic [1:0] S_RP_FRAME = 2'd3;

    localparam logic [REPLAY_IDX_W-1:0] REP_LAST = REPLAY_IDX_W'(REPLAY_DEPTH - 1);

    logic [1:0]              r_state, n_state;
    logic [REPLAY_IDX_W-1:0] r_rep_idx, n_rep_idx;
    logic                    in_frame;
    logic                    replay;
    logic                    next_frame;

    assign in_frame   = (r_state == S_FRAME) || (r_state == S_RP_FRAME);
    assign replay     = (r_state == S_RP_HUNT) || (r_state == S_RP_FRAME);
    // replayed bytes enter a frame the same way live bytes do
    assign next_frame = in_frame || i_status.start_byte;

    assign o_cmd = '{feed: replay || i_accept, in_frame: in_frame,
                     replay: replay, rep_idx: r_rep_idx};

    // phase sequencing
    always_comb begin
        n_state   = r_state;
        n_rep_idx = r_rep_idx;
        unique case (r_state) inside
            S_HUNT, S_FRAME: begin
                if (i_accept && next_frame) begin
                    if (i_status.oversize) begin
                        n_state   = S_RP_HUNT;
                        n_rep_idx = '0;
                    end else if (i_status.frame_end) begin
                        n_state = S_HUNT;
                    end else begin
                        n_state = S_FRAME;
                    end
                end
            end
            S_RP_HUNT, S_RP_FRAME: begin
                n_rep_idx = r_rep_idx + 1'b1;
                if (r_rep_idx == REP_LAST) begin
                    n_state = next_frame ? S_FRAME : S_HUNT;
                end else begin
                    n_state = next_frame ? S_RP_FRAME : S_RP_HUNT;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HUNT;
            r_rep_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_rep_idx <= n_rep_idx;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ltr_dpath.sv =====
`default_nettype none
module ltr_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ltr_pkg::t_ctrl_cmd  i_cmd,
    input  ltr_pkg::t_cfg       i_cfg,
    input  logic [7:0]          i_data_byte,
    output ltr_pkg::t_dp_status o_status,
    output logic                o_emit,
    output ltr_pkg::t_result    o_result
);
    import ltr_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_len, n_len;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_prev, n_prev;
    logic [7:0]         r_crc_low, n_crc_low;
    logic [7:0]         r_type, n_type;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_val_low, n_val_low;
    logic [7:0]         r_hold [REPLAY_DEPTH];

    logic [7:0]         b;
    logic               start;
    logic               proc;
    logic [POS_W-1:0]   p, len;
    logic [15:0]        crc, crc_step;
    logic [7:0]         prev, ftype;
    logic [COUNT_W-1:0] cnt;
    logic               in_payload;
    logic               hold_we;
    logic [REPLAY_IDX_W-1:0] hold_idx;
    logic               oversize, frame_end, meas_emit;
    logic [POS_W-1:0]   q, qm3;
    logic [COUNT_W-1:0] idx;
    logic [RANGE_W-1:0] raw_range;
    logic [POS_W-1:0]   plen;
    logic [POS_W:0]     need_len;
    logic               count_match;
    logic [STATUS_W-1:0] fstatus;

    // byte source: live link or held header during replay
    assign b     = i_cmd.replay ? r_hold[i_cmd.rep_idx] : i_data_byte;
    assign start = (b == STX_BYTE);
    assign proc  = i_cmd.feed && (i_cmd.in_frame || start);

    // a fresh frame starts from cleared state
    assign p     = i_cmd.in_frame ? r_pos   : '0;
    assign len   = i_cmd.in_frame ? r_len   : '0;
    assign crc   = i_cmd.in_frame ? r_crc   : '0;
    assign prev  = i_cmd.in_frame ? r_prev  : '0;
    assign ftype = i_cmd.in_frame ? r_type  : '0;
    assign cnt   = i_cmd.in_frame ? r_count : '0;

    assign crc_step   = {crc[14:0], 1'b0} ^ (crc[15] ? i_cfg.crc_polynomial : 16'h0000)
                        ^ {prev, b};
    assign in_payload = ({1'b0, p} + 18'd3) <= {1'b0, len};
    assign q          = p - 17'd4;
    assign qm3        = q - 17'd3;
    assign idx        = qm3[COUNT_W:1];
    assign raw_range  = {b[4:0], r_val_low};
    assign count_match = (cnt == {{(COUNT_W-11){1'b0}}, i_cfg.expected_count});

    // end-of-frame checks
    assign plen     = len - 17'(FRAME_OVERHEAD);
    assign need_len = 18'd3 + {1'b0, cnt, 1'b0};
    always_comb begin
        if ({b, r_crc_low} != crc) begin
            fstatus = FS_CRC_ERROR;
        end else if ((plen == '0) || (ftype != SCAN_TYPE)) begin
            fstatus = FS_UNKNOWN_TYPE;
        end else if ((plen < 17'd3) || !count_match || ({1'b0, plen} < need_len)) begin
            fstatus = FS_WRONG_COUNT;
        end else begin
            fstatus = FS_ACCEPTED;
        end
    end

    // per-byte update
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_crc     = r_crc;
        n_prev    = r_prev;
        n_crc_low = r_crc_low;
        n_type    = r_type;
        n_count   = r_count;
        n_val_low = r_val_low;
        hold_we   = 1'b0;
        hold_idx  = REPLAY_IDX_W'(p[REPLAY_IDX_W-1:0] - 1'b1);
        oversize  = 1'b0;
        frame_end = 1'b0;
        meas_emit = 1'b0;
        if (proc) begin
            n_len   = len;
            n_crc   = crc;
            n_prev  = prev;
            n_type  = ftype;
            n_count = cnt;
            if ((p < 17'd4) || in_payload) begin
                n_crc  = crc_step;
                n_prev = b;
            end
            hold_we = (p >= 17'd1) && (p <= 17'(REPLAY_DEPTH));
            if (p == 17'd2) begin
                n_len = {9'b0, b};
            end
            if (p == 17'd3) begin
                n_len = {1'b0, b, len[7:0]} + 17'(FRAME_OVERHEAD);
            end
            oversize = (p == 17'(REPLAY_DEPTH)) && (n_len > i_cfg.max_frame_bytes);
            if ((p >= 17'd4) && !oversize) begin
                if (in_payload) begin
                    if (q == 17'd0) begin
                        n_type = b;
                    end else if (q == 17'd1) begin
                        n_count = {8'b0, b};
                    end else if (q == 17'd2) begin
                        n_count = {b, cnt[7:0]};
                    end else if (!qm3[0]) begin
                        n_val_low = b;
                    end else begin
                        meas_emit = (ftype == SCAN_TYPE) && count_match && (idx < cnt)
                                    && ({1'b0, idx} < 17'(MAX_MEASUREMENTS));
                    end
                end else if (({1'b0, p} + 18'd2) == {1'b0, len}) begin
                    n_crc_low = b;
                end else begin
                    frame_end = 1'b1;
                end
            end
            n_pos = frame_end ? '0 : p + 17'd1;
        end
    end

    assign o_status = '{start_byte: start, oversize: oversize, frame_end: frame_end};
    assign o_emit   = proc && !i_cmd.replay && (meas_emit || frame_end);

    // result word
    always_comb begin
        o_result = '0;
        if (frame_end) begin
            o_result.item_kind    = KIND_STATUS;
            o_result.frame_status = fstatus;
            o_result.request_next = 1'b1;
        end else begin
            o_result.item_kind       = KIND_MEAS;
            o_result.meas_index      = idx[MEAS_INDEX_W-1:0];
            o_result.range_value     = (raw_range > i_cfg.max_range) ? i_cfg.max_range
                                                                     : raw_range;
            o_result.dazzle_flag     = b[5];
            o_result.warn_field_flag = b[6];
            o_result.stop_field_flag = b[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_crc     <= '0;
            r_prev    <= '0;
            r_crc_low <= '0;
            r_type    <= '0;
            r_count   <= '0;
            r_val_low <= '0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_prev    <= n_prev;
            r_crc_low <= n_crc_low;
            r_type    <= n_type;
            r_count   <= n_count;
            r_val_low <= n_val_low;
        end
    end

    // held header bytes 1..5
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_hold[hold_idx] <= b;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ltr_outq.sv =====
`default_nettype none
module ltr_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ltr_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output ltr_pkg::t_result o_data
);
    import ltr_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire
